### hw/rtl/psvm_pkg.sv
// Shared types and constants for the polyphonic sine voice mixer.
// Used by psvm_scale and the top level.
`timescale 1ns / 1ps
`default_nettype none
package psvm_pkg;
	localparam int VOICES_DEF = 16;
	localparam int FRAC_DEF   = 30;
	localparam int AMP_FRAC   = 12;
	localparam int MIX_W      = 56;
	localparam int ACC_W      = 65;
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic go;
		logic fin;
	} out_ctl_t;
endpackage
`default_nettype wire

### hw/rtl/psvm_mul.sv
// Shared signed 32 by 32 multiplier with a registered product.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module psvm_mul (
	input  wire logic               clk,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output logic signed [63:0]      p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule
`default_nettype wire

### hw/rtl/psvm_scale.sv
// Output stage: scales the mix by 32767, truncates, saturates and registers the result.
// Depends on psvm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psvm_scale #(
	parameter int FRAC_BITS = psvm_pkg::FRAC_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic signed [psvm_pkg::MIX_W-1:0]  mix,
	input  wire psvm_pkg::out_ctl_t                 ctl,
	output logic                                    strobe,
	output logic signed [15:0]                      sample,
	output logic                                    clipped,
	output logic                                    final_res
);
	localparam int MW = psvm_pkg::MIX_W;
	localparam int QS = FRAC_BITS + psvm_pkg::AMP_FRAC;

	logic          neg;
	logic [MW-1:0] mag;
	logic          big;
	logic [MW+14:0] prod;
	logic [16:0]   q;
	logic [15:0]   s_d;
	logic          c_d;

	always_comb begin
		neg  = mix[MW-1];
		mag  = neg ? MW'(-mix) : MW'(mix);
		big  = (mag >> (QS + 1)) != '0;
		prod = ({mag, 15'd0} - (MW+15)'(mag)) >> QS;
		q    = big ? 17'h10000 : prod[16:0];
		c_d  = 1'b0;
		if (neg) begin
			if (q > 17'd32768) begin
				q   = 17'd32768;
				c_d = 1'b1;
			end
			s_d = 16'(-q);
		end else begin
			if (q > 17'd32767) begin
				q   = 17'd32767;
				c_d = 1'b1;
			end
			s_d = q[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= ctl.go;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			sample    <= s_d;
			clipped   <= c_d;
			final_res <= ctl.fin;
		end
	end

	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && clipped |-> (sample == 16'sh7fff || sample == 16'sh8000))
		else $error("clip flag without saturated sample");
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result held longer than one cycle");
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(ctl.go))
		else $error("result without request");
endmodule
`default_nettype wire

### hw/rtl/polyphonic_sine_voice_mixer.sv
// Top level of the polyphonic sine voice mixer: voice memory, sequencer and datapath.
// Depends on psvm_pkg, psvm_mul and psvm_scale.
//
// Usage: an item is taken when start is high and busy is low. A note load
// (opcode 0) writes one voice slot in that cycle and leaves busy low. A tick
// (opcode 1) walks all voice slots through one shared 32x32 multiplier:
// each slot is read (S_RD) and checked (S_CHK), and a sounding voice then
// runs four rotation products and one amplitude product (S_P1 to S_P5);
// S_OUT ends the tick, and busy is high throughout.
// The sample appears at the clock edge at which busy falls, on sample, clipped and
// final_res, marked by strobe for exactly one cycle. The receiver cannot
// stall the block; each result must be taken when strobe is high.
// The user must write total_samples through cfg_wen and cfg_wdata only while idle;
// the block does not enforce it. Reset clears the sample counter, total_samples and
// all voice valid bits; voice stores are read only after a load has written them.
`timescale 1ns / 1ps
`default_nettype none
module polyphonic_sine_voice_mixer #(
	parameter int VOICES    = psvm_pkg::VOICES_DEF,
	parameter int FRAC_BITS = psvm_pkg::FRAC_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wen,
	input  wire logic [31:0]        cfg_wdata,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               opcode,
	input  wire logic [3:0]         slot,
	input  wire logic signed [31:0] step_cos,
	input  wire logic signed [31:0] step_sin,
	input  wire logic [15:0]        amplitude,
	input  wire logic [31:0]        start_sample,
	input  wire logic [31:0]        length_samples,
	output logic                    strobe,
	output logic signed [15:0]      sample,
	output logic                    clipped,
	output logic                    final_res
);
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AW = psvm_pkg::ACC_W;
	localparam int MW = psvm_pkg::MIX_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_P1   = 4'd3;
	localparam logic [3:0] S_P2   = 4'd4;
	localparam logic [3:0] S_P3   = 4'd5;
	localparam logic [3:0] S_P4   = 4'd6;
	localparam logic [3:0] S_P5   = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [31:0] m_cos [VOICES];
	logic [31:0] m_sin [VOICES];
	logic [15:0] m_amp [VOICES];
	logic [31:0] m_start [VOICES];
	logic [31:0] m_len [VOICES];
	logic [31:0] m_re [VOICES];
	logic [31:0] m_im [VOICES];

	logic signed [31:0] cos_q, sin_q, re_q, im_q;
	logic [15:0]        amp_q;
	logic [31:0]        start_q, len_q;

	logic [VOICES-1:0]  valid_q;
	logic [3:0]         state_q;
	logic [VW-1:0]      v_q;
	logic [31:0]        total_q;
	logic [31:0]        time_q;
	logic signed [AW-1:0] acc_q;
	logic signed [MW-1:0] mix_q;
	logic signed [31:0] re_new_q;

	logic               acc_in;
	logic               load_en;
	logic [6:0]         slot_x;
	logic [VW-1:0]      load_addr;
	logic               osc_we;
	logic [VW-1:0]      osc_addr;
	logic [31:0]        osc_re_d, osc_im_d;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic [31:0]        offs;
	logic               sounding;
	logic               last_v;
	psvm_pkg::out_ctl_t octl;

	function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] x);
		logic signed [AW-1:0] sh;
		sh = x >>> FRAC_BITS;
		if (sh > AW'(signed'(32'sh7fffffff))) begin
			return 32'sh7fffffff;
		end else if (sh < AW'(signed'(32'sh80000000))) begin
			return 32'sh80000000;
		end
		return sh[31:0];
	endfunction

	assign acc_in    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign slot_x    = 7'(slot);
	assign load_addr = slot_x[VW-1:0];
	assign load_en   = acc_in && (opcode == psvm_pkg::OP_LOAD) && (slot_x < 7'(VOICES));
	assign offs      = time_q - start_q;
	assign sounding  = valid_q[v_q] && (time_q >= start_q) && (offs <= len_q);
	assign last_v    = (v_q == VW'(VOICES - 1));

	always_comb begin
		osc_we   = load_en || (state_q == S_P5);
		osc_addr = load_en ? load_addr : v_q;
		osc_re_d = load_en ? (32'd1 << FRAC_BITS) : re_new_q;
		osc_im_d = load_en ? 32'd0 : sat32(acc_q);
	end

	always_comb begin
		mul_a = im_q;
		mul_b = cos_q;
		unique case (state_q)
			S_CHK: begin
				mul_a = re_q;
				mul_b = cos_q;
			end
			S_P1: begin
				mul_a = im_q;
				mul_b = sin_q;
			end
			S_P2: begin
				mul_a = re_q;
				mul_b = sin_q;
			end
			S_P4: begin
				mul_a = im_q;
				mul_b = signed'({16'd0, amp_q});
			end
			default: begin
				mul_a = im_q;
				mul_b = cos_q;
			end
		endcase
	end

	psvm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	always_ff @(posedge clk) begin
		if (load_en) begin
			m_cos[load_addr]   <= step_cos;
			m_sin[load_addr]   <= step_sin;
			m_amp[load_addr]   <= amplitude;
			m_start[load_addr] <= start_sample;
			m_len[load_addr]   <= length_samples;
		end
		if (osc_we) begin
			m_re[osc_addr] <= osc_re_d;
			m_im[osc_addr] <= osc_im_d;
		end
		cos_q   <= m_cos[v_q];
		sin_q   <= m_sin[v_q];
		amp_q   <= m_amp[v_q];
		start_q <= m_start[v_q];
		len_q   <= m_len[v_q];
		re_q    <= m_re[v_q];
		im_q    <= m_im[v_q];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_P1: acc_q <= AW'(prod);
			S_P2: acc_q <= acc_q - AW'(prod);
			S_P3: begin
				re_new_q <= sat32(acc_q);
				acc_q    <= AW'(prod);
			end
			S_P4: acc_q <= acc_q + AW'(prod);
			default: acc_q <= acc_q;
		endcase
		if (acc_in) begin
			mix_q <= '0;
		end else if (state_q == S_P5) begin
			mix_q <= mix_q + MW'(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			v_q     <= '0;
			valid_q <= '0;
			total_q <= '0;
			time_q  <= '0;
		end else begin
			if (cfg_wen) begin
				total_q <= cfg_wdata;
			end
			if (load_en) begin
				valid_q[load_addr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					v_q <= '0;
					if (acc_in && opcode == psvm_pkg::OP_TICK) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (sounding) begin
						state_q <= S_P1;
					end else if (last_v) begin
						state_q <= S_OUT;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: state_q <= S_P5;
				S_P5: begin
					if (last_v) begin
						state_q <= S_OUT;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					time_q  <= time_q + 32'd1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign octl.go  = (state_q == S_OUT);
	assign octl.fin = (total_q != 32'd0) && (time_q == total_q - 32'd1);

	psvm_scale #(
		.FRAC_BITS (FRAC_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.mix       (mix_q),
		.ctl       (octl),
		.strobe    (strobe),
		.sample    (sample),
		.clipped   (clipped),
		.final_res (final_res)
	);

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && opcode == psvm_pkg::OP_TICK |=> state_q == S_RD)
		else $error("tick item did not start the voice walk");
	a_voice_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (int'(v_q) < VOICES))
		else $error("voice index out of range");
	a_out_time: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |=> time_q == $past(time_q) + 32'd1)
		else $error("sample counter did not advance");
endmodule
`default_nettype wire
